FILE: sv/dlrr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dlrr_pkg;

	localparam int NUM_NODES_DEF = 8;

	localparam int CMD_W  = 2;
	localparam int ID_W   = 3;
	localparam int SEQ_W  = 16;
	localparam int KIND_W = 2;

	localparam logic [CMD_W-1:0] CMD_LOCAL_REQ  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_RECV_REQ   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RECV_REPLY = 2'd2;
	localparam logic [CMD_W-1:0] CMD_RELEASE    = 2'd3;

	localparam logic [KIND_W-1:0] KIND_NONE    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_REQUEST = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REPLY   = 2'd2;

	typedef struct packed {
		logic load;
		logic exec;
		logic emit;
	} dlrr_ctrl_t;

	typedef struct packed {
		logic out_free;
		logic next_last;
	} dlrr_stat_t;

endpackage

`default_nettype wire

FILE: sv/distributed_lock_request_reply_core.sv
`timescale 1ns / 1ps
`default_nettype none

// One node of Ricart-Agrawala mutual exclusion with reuse of held replies. Each accepted
// command (local request, received request, received reply, local release) is captured,
// run in ST_EXEC, and in ST_EMIT gives a status item, a reply (and maybe a new request), or
// up to NUM_NODES - 1 messages for a request or release. The peer scan picks the lowest
// pending peer and loads one message per cycle into the output register; a stall stretches
// the run. The next command is taken once the last result sits in the output register.
// The user must write node_id with cfg_we only while idle; the block does not enforce it.
module distributed_lock_request_reply_core #(
	parameter int NUM_NODES = dlrr_pkg::NUM_NODES_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [dlrr_pkg::ID_W-1:0]  cfg_wdata,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [dlrr_pkg::CMD_W-1:0] cmd,
	input  wire logic [dlrr_pkg::ID_W-1:0]  peer_id,
	input  wire logic [dlrr_pkg::SEQ_W-1:0] peer_seq,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [dlrr_pkg::KIND_W-1:0]     msg_kind,
	output logic [dlrr_pkg::ID_W-1:0]       dest_id,
	output logic [dlrr_pkg::SEQ_W-1:0]      msg_seq,
	output logic                            grant,
	output logic                            last
);
	import dlrr_pkg::*;

	dlrr_ctrl_t ctrl;
	dlrr_stat_t stat;

	dlrr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.ctrl     (ctrl),
		.stat     (stat)
	);

	dlrr_dp #(
		.NUM_NODES (NUM_NODES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.stat      (stat),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.peer_id   (peer_id),
		.peer_seq  (peer_seq),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.msg_kind  (msg_kind),
		.dest_id   (dest_id),
		.msg_seq   (msg_seq),
		.grant     (grant),
		.last      (last)
	);

	// one command in flight at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second command taken while one is in flight");

	a_grant_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && grant) |-> ((msg_kind == KIND_NONE) && last))
		else $error("grant on a message transfer");

	a_request_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (msg_kind == KIND_REQUEST)) |-> (msg_seq != '0))
		else $error("request carries zero sequence");

	a_reply_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (msg_kind == KIND_REPLY)) |-> (msg_seq == '0))
		else $error("reply carries a sequence");

endmodule

`default_nettype wire

FILE: sv/dlrr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module dlrr_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	output dlrr_pkg::dlrr_ctrl_t      ctrl,
	input  wire dlrr_pkg::dlrr_stat_t stat
);
	import dlrr_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic   ready_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ready_q <= 1'b1;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid && ready_q) begin
						state_q <= ST_EXEC;
						ready_q <= 1'b0;
					end
				end
				ST_EXEC: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (stat.out_free && stat.next_last) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

	assign in_ready  = ready_q;
	assign ctrl.load = in_valid && ready_q;
	assign ctrl.exec = (state_q == ST_EXEC);
	assign ctrl.emit = (state_q == ST_EMIT);

endmodule

`default_nettype wire

FILE: sv/dlrr_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module dlrr_dp #(
	parameter int NUM_NODES = dlrr_pkg::NUM_NODES_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire dlrr_pkg::dlrr_ctrl_t        ctrl,
	output dlrr_pkg::dlrr_stat_t             stat,
	input  wire logic                        cfg_we,
	input  wire logic [dlrr_pkg::ID_W-1:0]   cfg_wdata,
	input  wire logic [dlrr_pkg::CMD_W-1:0]  cmd,
	input  wire logic [dlrr_pkg::ID_W-1:0]   peer_id,
	input  wire logic [dlrr_pkg::SEQ_W-1:0]  peer_seq,
	input  wire logic                        out_ready,
	output logic                             out_valid,
	output logic [dlrr_pkg::KIND_W-1:0]      msg_kind,
	output logic [dlrr_pkg::ID_W-1:0]        dest_id,
	output logic [dlrr_pkg::SEQ_W-1:0]       msg_seq,
	output logic                             grant,
	output logic                             last
);
	import dlrr_pkg::*;

	logic [ID_W-1:0]      node_id_q;
	logic [SEQ_W-1:0]     own_seq_q;
	logic [SEQ_W-1:0]     high_seq_q;
	logic                 in_sec_q;
	logic                 wait_q;
	logic [NUM_NODES-1:0] held_q;
	logic [NUM_NODES-1:0] def_q;

	logic [CMD_W-1:0]     cmd_q;
	logic [ID_W-1:0]      peer_q;
	logic [SEQ_W-1:0]     pseq_q;

	logic [NUM_NODES-1:0] pend_q;
	logic [KIND_W-1:0]    kind_q;
	logic                 extra_q;
	logic                 grant_q;

	logic                 out_valid_q;
	logic [KIND_W-1:0]    kind_out_q;
	logic [ID_W-1:0]      dest_out_q;
	logic [SEQ_W-1:0]     seq_out_q;
	logic                 grant_out_q;
	logic                 last_out_q;

	logic [NUM_NODES-1:0] self_mask;
	logic [NUM_NODES-1:0] peer_mask;
	logic [NUM_NODES-1:0] held_new;
	logic [NUM_NODES-1:0] req_mask;
	logic [NUM_NODES-1:0] rel_mask;
	logic [NUM_NODES-1:0] pick_mask;
	logic [NUM_NODES-1:0] rest_mask;
	logic [ID_W-1:0]      pick_dest;
	logic                 peer_ok;
	logic                 all_held;
	logic                 lower;
	logic [SEQ_W-1:0]     next_own;
	logic                 out_free;
	logic                 fire;
	logic                 next_last;
	logic [KIND_W-1:0]    next_kind;
	logic [ID_W-1:0]      next_dest;
	logic [SEQ_W-1:0]     next_seq;
	logic                 next_grant;

	always_comb begin
		self_mask = '0;
		peer_mask = '0;
		pick_dest = '0;
		for (int i = 0; i < NUM_NODES; i++) begin
			self_mask[i] = (int'(node_id_q) == i);
			peer_mask[i] = (int'(peer_q) == i);
			if (pick_mask[i]) begin
				pick_dest = ID_W'(i);
			end
		end
	end

	assign peer_ok   = (int'(peer_q) < NUM_NODES) && (peer_q != node_id_q);
	assign held_new  = held_q | peer_mask;
	assign all_held  = &(held_new | self_mask);
	assign lower     = (pseq_q > own_seq_q) || ((pseq_q == own_seq_q) && (peer_q > node_id_q));
	assign req_mask  = ~held_q & ~self_mask;
	assign rel_mask  = def_q & ~self_mask;
	assign next_own  = (high_seq_q == '1) ? high_seq_q : high_seq_q + {{(SEQ_W-1){1'b0}}, 1'b1};

	// lowest pending peer goes out first
	assign pick_mask = pend_q & (~pend_q + {{(NUM_NODES-1){1'b0}}, 1'b1});
	assign rest_mask = pend_q & ~pick_mask;

	always_comb begin
		if (pend_q != '0) begin
			next_kind  = kind_q;
			next_dest  = pick_dest;
			next_seq   = (kind_q == KIND_REQUEST) ? own_seq_q : '0;
			next_grant = 1'b0;
			next_last  = (rest_mask == '0) && !extra_q;
		end else if (extra_q) begin
			next_kind  = KIND_REQUEST;
			next_dest  = peer_q;
			next_seq   = own_seq_q;
			next_grant = 1'b0;
			next_last  = 1'b1;
		end else begin
			next_kind  = KIND_NONE;
			next_dest  = '0;
			next_seq   = '0;
			next_grant = grant_q;
			next_last  = 1'b1;
		end
	end

	assign out_free = !out_valid_q || out_ready;
	assign fire     = ctrl.emit && out_free;

	assign stat.out_free  = out_free;
	assign stat.next_last = next_last;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			cmd_q  <= cmd;
			peer_q <= peer_id;
			pseq_q <= peer_seq;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_id_q  <= '0;
			own_seq_q  <= '0;
			high_seq_q <= '0;
			in_sec_q   <= 1'b0;
			wait_q     <= 1'b0;
			held_q     <= '0;
			def_q      <= '0;
			pend_q     <= '0;
			kind_q     <= KIND_NONE;
			extra_q    <= 1'b0;
			grant_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				node_id_q <= cfg_wdata;
			end
			if (ctrl.exec) begin
				pend_q  <= '0;
				kind_q  <= KIND_NONE;
				extra_q <= 1'b0;
				grant_q <= 1'b0;
				case (cmd_q)
					CMD_LOCAL_REQ: begin
						if (!wait_q && !in_sec_q) begin
							own_seq_q <= next_own;
							if (req_mask == '0) begin
								in_sec_q <= 1'b1;
								grant_q  <= 1'b1;
							end else begin
								wait_q <= 1'b1;
								pend_q <= req_mask;
								kind_q <= KIND_REQUEST;
							end
						end
					end
					CMD_RECV_REQ: begin
						if (peer_ok) begin
							if (pseq_q > high_seq_q) begin
								high_seq_q <= pseq_q;
							end
							if (in_sec_q || (wait_q && lower)) begin
								def_q <= def_q | peer_mask;
							end else begin
								held_q  <= held_q & ~peer_mask;
								pend_q  <= peer_mask;
								kind_q  <= KIND_REPLY;
								extra_q <= wait_q && ((held_q & peer_mask) != '0);
							end
						end
					end
					CMD_RECV_REPLY: begin
						if (peer_ok) begin
							held_q <= held_new;
							if (wait_q && all_held) begin
								in_sec_q <= 1'b1;
								wait_q   <= 1'b0;
								grant_q  <= 1'b1;
							end
						end
					end
					CMD_RELEASE: begin
						if (in_sec_q) begin
							in_sec_q <= 1'b0;
							def_q    <= def_q & ~rel_mask;
							held_q   <= held_q & ~rel_mask;
							pend_q   <= rel_mask;
							kind_q   <= KIND_REPLY;
						end
					end
					default: begin
						pend_q <= '0;
					end
				endcase
			end else if (fire) begin
				if (pend_q != '0) begin
					pend_q <= rest_mask;
				end else begin
					extra_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			kind_out_q  <= next_kind;
			dest_out_q  <= next_dest;
			seq_out_q   <= next_seq;
			grant_out_q <= next_grant;
			last_out_q  <= next_last;
		end
	end

	assign out_valid = out_valid_q;
	assign msg_kind  = kind_out_q;
	assign dest_id   = dest_out_q;
	assign msg_seq   = seq_out_q;
	assign grant     = grant_out_q;
	assign last      = last_out_q;

endmodule

`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;
	import dlrr_pkg::*;

	localparam int NUM_NODES   = NUM_NODES_DEF;
	localparam int HOLD_CYCLES = 200;
	localparam int STALL_LIMIT = 3000;

	typedef enum logic [1:0] {IDLE_OFF, IDLE_SRC, IDLE_SINK, IDLE_BOTH} idle_mode_t;
	typedef enum logic [1:0] {SEQ_FIXED, SEQ_TIE, SEQ_ABOVE, SEQ_BELOW} seq_mode_t;

	typedef struct {
		logic [CMD_W-1:0] cmd;
		logic [ID_W-1:0]  peer;
		logic [SEQ_W-1:0] seq;
		seq_mode_t        mode;
	} lock_cmd_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ID_W-1:0]   dest;
		logic [SEQ_W-1:0]  seq;
		logic              grant;
		logic              last;
	} lock_result_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              cfg_we    = 1'b0;
	logic [ID_W-1:0]   cfg_wdata = '0;
	logic              in_valid  = 1'b0;
	logic              in_ready;
	logic [CMD_W-1:0]  cmd       = '0;
	logic [ID_W-1:0]   peer_id   = '0;
	logic [SEQ_W-1:0]  peer_seq  = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [KIND_W-1:0] msg_kind;
	logic [ID_W-1:0]   dest_id;
	logic [SEQ_W-1:0]  msg_seq;
	logic              grant;
	logic              last;

	distributed_lock_request_reply_core #(
		.NUM_NODES(NUM_NODES)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.peer_id(peer_id),
		.peer_seq(peer_seq),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.msg_kind(msg_kind),
		.dest_id(dest_id),
		.msg_seq(msg_seq),
		.grant(grant),
		.last(last)
	);

	// lock node shadow state
	logic [ID_W-1:0]  node_cfg;
	logic [SEQ_W-1:0] my_seq;
	logic [SEQ_W-1:0] top_seen_seq;
	logic             in_cs;
	logic             wants_cs;
	logic             held_reply [NUM_NODES];
	logic             deferred_reply [NUM_NODES];

	lock_cmd_t    pending_cmds [$];
	lock_result_t pending_results [$];

	idle_mode_t idle_mode = IDLE_OFF;
	int         mismatches = 0;
	logic       hold_req = 1'b0;
	int         hold_left = 0;
	int         quiet_cycles = 0;
	logic       src_busy;
	lock_cmd_t  next_cmd;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic lock_result_t lock_msg(input logic [KIND_W-1:0] kind,
			input logic [ID_W-1:0] dest, input logic [SEQ_W-1:0] seq, input logic gr);
		lock_result_t r;
		r.kind  = kind;
		r.dest  = dest;
		r.seq   = seq;
		r.grant = gr;
		r.last  = 1'b0;
		return r;
	endfunction

	function automatic logic all_replies_held();
		logic ok;
		ok = 1'b1;
		for (int i = 0; i < NUM_NODES; i++) begin
			if (i != node_cfg && !held_reply[i])
				ok = 1'b0;
		end
		return ok;
	endfunction

	task automatic node_step(input logic [CMD_W-1:0] c, input logic [ID_W-1:0] p,
			input logic [SEQ_W-1:0] s);
		lock_result_t res [NUM_NODES];
		int n;
		logic peer_ok, lower, again;
		n = 0;
		peer_ok = (p < NUM_NODES) && (p != node_cfg);
		case (c)
			CMD_LOCAL_REQ: begin
				if (!wants_cs && !in_cs) begin
					my_seq = (top_seen_seq == 16'hFFFF) ? 16'hFFFF : top_seen_seq + 16'd1;
					wants_cs = 1'b1;
					for (int i = 0; i < NUM_NODES; i++) begin
						if (i != node_cfg && !held_reply[i]) begin
							res[n] = lock_msg(KIND_REQUEST, ID_W'(i), my_seq, 1'b0);
							n++;
						end
					end
					if (n == 0) begin
						in_cs = 1'b1;
						wants_cs = 1'b0;
						res[0] = lock_msg(KIND_NONE, '0, '0, 1'b1);
						n = 1;
					end
				end
			end
			CMD_RECV_REQ: begin
				if (peer_ok) begin
					if (s > top_seen_seq)
						top_seen_seq = s;
					lower = (s > my_seq) || (s == my_seq && p > node_cfg);
					if (in_cs || (wants_cs && lower)) begin
						deferred_reply[p] = 1'b1;
					end else begin
						again = wants_cs && held_reply[p];
						held_reply[p] = 1'b0;
						res[0] = lock_msg(KIND_REPLY, p, '0, 1'b0);
						n = 1;
						if (again) begin
							res[1] = lock_msg(KIND_REQUEST, p, my_seq, 1'b0);
							n = 2;
						end
					end
				end
			end
			CMD_RECV_REPLY: begin
				if (peer_ok) begin
					held_reply[p] = 1'b1;
					if (wants_cs && all_replies_held()) begin
						in_cs = 1'b1;
						wants_cs = 1'b0;
						res[0] = lock_msg(KIND_NONE, '0, '0, 1'b1);
						n = 1;
					end
				end
			end
			default: begin
				if (in_cs) begin
					in_cs = 1'b0;
					for (int i = 0; i < NUM_NODES; i++) begin
						if (i != node_cfg && deferred_reply[i]) begin
							deferred_reply[i] = 1'b0;
							held_reply[i] = 1'b0;
							res[n] = lock_msg(KIND_REPLY, ID_W'(i), '0, 1'b0);
							n++;
						end
					end
				end
			end
		endcase
		if (n == 0) begin
			res[0] = lock_msg(KIND_NONE, '0, '0, 1'b0);
			n = 1;
		end
		res[n-1].last = 1'b1;
		for (int i = 0; i < n; i++)
			pending_results.push_back(res[i]);
	endtask

	function automatic logic [SEQ_W-1:0] resolve_seq(input lock_cmd_t c);
		case (c.mode)
			SEQ_TIE:   return my_seq;
			SEQ_ABOVE: return my_seq + 16'd1;
			SEQ_BELOW: return my_seq - 16'd1;
			default:   return c.seq;
		endcase
	endfunction

	function automatic logic src_idles();
		case (idle_mode)
			IDLE_SRC:  return $urandom_range(99) < 77;
			IDLE_BOTH: return $urandom_range(99) < 38;
			default:   return 1'b0;
		endcase
	endfunction

	function automatic logic sink_stalls();
		case (idle_mode)
			IDLE_SINK: return $urandom_range(99) < 77;
			IDLE_BOTH: return $urandom_range(99) < 38;
			default:   return 1'b0;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	task automatic check_result();
		lock_result_t want;
		if (pending_results.size() == 0) begin
			report_mismatch("result with none pending, msg_kind", msg_kind, 0);
		end else begin
			want = pending_results.pop_front();
			if (msg_kind !== want.kind)
				report_mismatch("msg_kind", msg_kind, want.kind);
			if (dest_id !== want.dest)
				report_mismatch("dest_id", dest_id, want.dest);
			if (msg_seq !== want.seq)
				report_mismatch("msg_seq", msg_seq, want.seq);
			if (grant !== want.grant)
				report_mismatch("grant", grant, want.grant);
			if (last !== want.last)
				report_mismatch("last", last, want.last);
		end
	endtask

	// command driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			src_busy = in_valid;
			if (in_valid && in_ready) begin
				node_step(cmd, peer_id, peer_seq);
				src_busy = 1'b0;
			end
			if (!src_busy) begin
				if (pending_cmds.size() != 0 && !src_idles()) begin
					next_cmd = pending_cmds.pop_front();
					in_valid <= 1'b1;
					cmd      <= next_cmd.cmd;
					peer_id  <= next_cmd.peer;
					peer_seq <= resolve_seq(next_cmd);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				check_result();
			out_ready <= (hold_left == 0) && !sink_stalls();
		end
	end

	// long receiver hold-off
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("no transfer for %0d cycles", STALL_LIMIT);
				$display("** distributed_lock_request_reply_core: FAILED **");
				$finish;
			end
		end
	end

	task automatic add_cmd(input logic [CMD_W-1:0] c, input logic [ID_W-1:0] p,
			input logic [SEQ_W-1:0] s, input seq_mode_t m);
		lock_cmd_t item;
		item.cmd  = c;
		item.peer = p;
		item.seq  = s;
		item.mode = m;
		pending_cmds.push_back(item);
	endtask

	task automatic add_peer_req();
		logic [ID_W-1:0] p;
		p = ID_W'($urandom_range(NUM_NODES - 1));
		case ($urandom_range(7))
			0:       add_cmd(CMD_RECV_REQ, p, SEQ_W'($urandom), SEQ_FIXED);
			1, 2:    add_cmd(CMD_RECV_REQ, p, SEQ_W'($urandom_range(300)), SEQ_FIXED);
			3, 4:    add_cmd(CMD_RECV_REQ, p, '0, SEQ_TIE);
			5:       add_cmd(CMD_RECV_REQ, p, '0, SEQ_ABOVE);
			6:       add_cmd(CMD_RECV_REQ, p, '0, SEQ_BELOW);
			default: add_cmd(CMD_RECV_REQ, p, '0, SEQ_FIXED);
		endcase
	endtask

	// request, replies from peers in random order (each may be skipped) with crossing requests, release
	task automatic add_round(input logic [ID_W-1:0] node);
		int peers [$];
		int j, t;
		for (int i = 0; i < NUM_NODES; i++) begin
			if (i != node)
				peers.push_back(i);
		end
		for (int i = peers.size() - 1; i > 0; i--) begin
			j = $urandom_range(i);
			t = peers[i];
			peers[i] = peers[j];
			peers[j] = t;
		end
		add_cmd(CMD_LOCAL_REQ, '0, '0, SEQ_FIXED);
		foreach (peers[i]) begin
			if ($urandom_range(99) < 25)
				add_peer_req();
			if ($urandom_range(99) >= 5)
				add_cmd(CMD_RECV_REPLY, ID_W'(peers[i]), '0, SEQ_FIXED);
		end
		if ($urandom_range(99) < 40)
			add_peer_req();
		add_cmd(CMD_RELEASE, ID_W'($urandom), SEQ_W'($urandom), SEQ_FIXED);
	endtask

	task automatic add_random(input logic [ID_W-1:0] node, input int count);
		while (pending_cmds.size() < count) begin
			if ($urandom_range(99) < 80)
				add_round(node);
			else
				add_cmd(CMD_W'($urandom), ID_W'($urandom), SEQ_W'($urandom), SEQ_FIXED);
		end
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_cmds.size() != 0 || in_valid || pending_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_node(input logic [ID_W-1:0] v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we   <= 1'b0;
		node_cfg = v;
		@(negedge clk);
	endtask

	task automatic run_random(input logic [ID_W-1:0] node, input idle_mode_t m,
			input int count, input logic pressure);
		wait_drained();
		write_node(node);
		idle_mode = m;
		add_random(node, count);
		if (pressure)
			hold_req = 1'b1;
	endtask

	initial begin
		node_cfg     = '0;
		my_seq       = '0;
		top_seen_seq = '0;
		in_cs        = 1'b0;
		wants_cs     = 1'b0;
		for (int i = 0; i < NUM_NODES; i++) begin
			held_reply[i]     = 1'b0;
			deferred_reply[i] = 1'b0;
		end
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_node(3'd3);
		idle_mode = IDLE_OFF;
		add_cmd(CMD_RELEASE, '0, '0, SEQ_FIXED);
		add_cmd(CMD_RECV_REPLY, 3'd3, '0, SEQ_FIXED);
		add_cmd(CMD_RECV_REQ, 3'd3, '0, SEQ_FIXED);
		add_cmd(CMD_RECV_REPLY, 3'd1, '0, SEQ_FIXED);
		add_cmd(CMD_LOCAL_REQ, '0, '0, SEQ_FIXED);
		add_cmd(CMD_LOCAL_REQ, '0, '0, SEQ_FIXED);
		add_cmd(CMD_RECV_REQ, 3'd5, '0, SEQ_ABOVE);
		add_cmd(CMD_RECV_REQ, 3'd4, '0, SEQ_TIE);
		add_cmd(CMD_RECV_REQ, 3'd1, '0, SEQ_FIXED);
		add_cmd(CMD_RECV_REQ, 3'd2, '0, SEQ_TIE);
		add_cmd(CMD_RECV_REPLY, 3'd0, '0, SEQ_FIXED);
		add_cmd(CMD_RECV_REPLY, 3'd1, '0, SEQ_FIXED);
		add_cmd(CMD_RECV_REPLY, 3'd2, '0, SEQ_FIXED);
		add_cmd(CMD_RECV_REPLY, 3'd4, '0, SEQ_FIXED);
		add_cmd(CMD_RECV_REPLY, 3'd5, '0, SEQ_FIXED);
		add_cmd(CMD_RECV_REPLY, 3'd6, '0, SEQ_FIXED);
		add_cmd(CMD_RECV_REPLY, 3'd7, '0, SEQ_FIXED);
		add_cmd(CMD_RECV_REQ, 3'd6, 16'd7, SEQ_FIXED);
		add_cmd(CMD_RELEASE, '0, '0, SEQ_FIXED);
		add_cmd(CMD_RECV_REPLY, 3'd4, '0, SEQ_FIXED);
		add_cmd(CMD_RECV_REPLY, 3'd5, '0, SEQ_FIXED);
		add_cmd(CMD_RECV_REPLY, 3'd6, '0, SEQ_FIXED);
		add_cmd(CMD_LOCAL_REQ, '0, '0, SEQ_FIXED);
		add_cmd(CMD_RELEASE, '0, '0, SEQ_FIXED);

		run_random(3'd0, IDLE_OFF, 16, 1'b1);
		run_random(3'd7, IDLE_SRC, 14, 1'b0);
		run_random(ID_W'($urandom), IDLE_SINK, 14, 1'b0);
		run_random(ID_W'($urandom), IDLE_BOTH, 14, 1'b0);
		run_random(3'd0, IDLE_OFF, 12, 1'b0);

		// sequence numbers pinned at the top of their range
		wait_drained();
		write_node(3'd7);
		idle_mode = IDLE_BOTH;
		add_cmd(CMD_RECV_REQ, 3'd0, 16'hFFFF, SEQ_FIXED);
		add_cmd(CMD_LOCAL_REQ, '0, '0, SEQ_FIXED);
		add_cmd(CMD_RECV_REQ, 3'd6, '0, SEQ_TIE);
		add_cmd(CMD_RECV_REQ, 3'd1, 16'hFFFF, SEQ_FIXED);
		for (int i = 0; i < 7; i++)
			add_cmd(CMD_RECV_REPLY, ID_W'(i), '0, SEQ_FIXED);
		add_cmd(CMD_RELEASE, '0, '0, SEQ_FIXED);
		add_cmd(CMD_LOCAL_REQ, '0, '0, SEQ_FIXED);
		add_cmd(CMD_RECV_REQ, 3'd2, 16'hFFFF, SEQ_FIXED);

		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("** distributed_lock_request_reply_core: PASSED **");
		else
			$display("** distributed_lock_request_reply_core: FAILED **");
		$finish;
	end

endmodule
